FILE: hdl/wma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wma_pkg: shared definitions for the warm-up moving average
// Window size, widths, control state codes and divider handshake structs.
// ---------------------------------------------------------------------------
package wma_pkg;

  localparam int unsigned WINDOW      = 10;
  localparam int unsigned SAMPLE_BITS = 16;
  // running sum holds WINDOW full-scale samples with one spare bit
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int unsigned COUNT_BITS  = $clog2(WINDOW + 1);
  localparam int unsigned CNT_FIELD_BITS = 4;
  localparam int unsigned STEP_BITS   = $clog2(SUM_BITS + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } wma_state_e;

  typedef struct packed {
    logic start;
  } wma_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wma_div_sts_t;

endpackage

`default_nettype wire

FILE: hdl/wma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wma channel interfaces
// Valid/ready channels for the sample request and the average result.
// ---------------------------------------------------------------------------
interface wma_sample_if
  import wma_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_milliamps;

  modport source (output valid, output sample_milliamps, input ready);
  modport sink   (input valid, input sample_milliamps, output ready);
endinterface

interface wma_avg_if
  import wma_pkg::*;
();
  logic                      valid;
  logic                      ready;
  sample_t                   average_milliamps;
  logic [CNT_FIELD_BITS-1:0] filled_count;

  modport source (output valid, output average_milliamps, output filled_count, input ready);
  modport sink   (input valid, input average_milliamps, input filled_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/wma_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wma_cell: one window entry
// Holds one sample and passes it to the next cell on every shift.
// ---------------------------------------------------------------------------
module wma_cell
  import wma_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire sample_t sample_i,
  output sample_t      sample_o
);

  sample_t sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

FILE: hdl/wma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wma_div: signed sum by fill count divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module wma_div
  import wma_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire wma_div_req_t req_i,
  input  wire sum_t         sum_i,
  input  wire count_t       divisor_i,
  output wma_div_sts_t      sts_o,
  output sample_t           quotient_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [STEP_BITS-1:0]    step_q, step_d;
  logic                    neg_q, neg_d;
  logic [SUM_BITS-1:0]     quo_q, quo_d;
  logic [COUNT_BITS-1:0]   rem_q, rem_d;
  count_t                  dvs_q, dvs_d;
  logic [COUNT_BITS:0]     trial;
  logic                    ge;
  logic [SUM_BITS-1:0]     signed_quo;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[SUM_BITS-1]};
    ge     = (trial >= {1'b0, dvs_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = sum_i[SUM_BITS-1];
      quo_d  = sum_i[SUM_BITS-1] ? (~sum_i + 1'b1) : sum_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
      quo_d = {quo_q[SUM_BITS-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = signed_quo[SAMPLE_BITS-1:0];
  assign sts_o      = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

FILE: hdl/warmup_moving_average_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// warmup_moving_average_core: moving average with warm-up
// Averages the last WINDOW current samples, or all seen so far while filling.
// ---------------------------------------------------------------------------
// Each sample request shifts a row of WINDOW sample cells; the sample falling
// off the far end leaves the running sum as the new one enters. The sum is
// then divided by the fill count in a one-bit-per-cycle restoring divider.
// A request is accepted, loads the divider, runs SUM_BITS divide steps,
// flags completion and hands the result to the output register. The output
// register lets the next sample be accepted while a result still waits;
// work on that sample stalls only at its hand-off if the result is not
// taken. Reset clears the cells, the sum and the fill count at once.
module warmup_moving_average_core
  import wma_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  wma_sample_if.sink   sample_i,
  wma_avg_if.source    average_o
);

  // control state
  wma_state_e state_q, state_d;
  logic       in_fire;
  logic       out_load;

  // running sum and fill count
  sum_t   sum_q, sum_d;
  count_t fill_q, fill_d;

  // cell row: entry 0 is the newest sample, the last one the oldest
  sample_t cell_in  [WINDOW];
  sample_t cell_out [WINDOW];

  // divider
  wma_div_req_t div_req;
  wma_div_sts_t div_sts;
  sample_t      quotient;

  // output register
  logic                      out_valid_q;
  sample_t                   avg_q;
  logic [CNT_FIELD_BITS-1:0] cnt_q;
  logic [COUNT_BITS+CNT_FIELD_BITS-1:0] fill_wide;

  assign in_fire         = sample_i.valid && sample_i.ready;
  assign sample_i.ready  = (state_q == ST_IDLE);

  // shift line of sample cells
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = sample_i.sample_milliamps;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end
    wma_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (in_fire),
      .sample_i (cell_in[i]),
      .sample_o (cell_out[i])
    );
  end

  // drop the oldest sample, add the new one; unwritten cells hold zero
  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    if (in_fire) begin
      sum_d = sum_q
            - {{(SUM_BITS-SAMPLE_BITS){cell_out[WINDOW-1][SAMPLE_BITS-1]}},
               cell_out[WINDOW-1]}
            + {{(SUM_BITS-SAMPLE_BITS){sample_i.sample_milliamps[SAMPLE_BITS-1]}},
               sample_i.sample_milliamps};
      if (fill_q < COUNT_BITS'(WINDOW)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous result is still held
        if (!out_valid_q || average_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  wma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .sum_i      (sum_q),
    .divisor_i  (fill_q),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  // count field is reported modulo 16
  assign fill_wide = {{CNT_FIELD_BITS{1'b0}}, fill_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (average_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q <= quotient;
      cnt_q <= fill_wide[CNT_FIELD_BITS-1:0];
    end
  end

  assign average_o.valid             = out_valid_q;
  assign average_o.average_milliamps = avg_q;
  assign average_o.filled_count      = cnt_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= COUNT_BITS'(WINDOW))
    else $error("fill count beyond window");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_LOAD))
    else $error("accepted request did not start the divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_result_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result shown without a finished division");

  a_sum_stable_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> $stable(sum_q))
    else $error("running sum moved during division");
`endif

endmodule

`default_nettype wire
